// ----- src/cgdn_pkg.sv -----
// Shared types, constants and helpers for the calendar grid day lookup.
// No dependencies; every other file refers to it by scoped names.
package cgdn_pkg;

    localparam int unsigned YEAR_W = 14;
    localparam int unsigned YW     = YEAR_W + 1;  // room for year + 1

    // register stages from request to result
    localparam int unsigned NSTG = 5;

    localparam logic [YW-1:0] YEAR_GREG_CUT   = 15'd1800;
    localparam logic [YW-1:0] YEAR_SWITCH     = 15'd1752;
    localparam logic [YW-1:0] YEAR_CENT_BASE  = 15'd1701;
    localparam logic [YW-1:0] YEAR_QUAD_BASE  = 15'd1601;

    // floor(x / 100) = (x * 5243) >> 19 for every x below 2**15
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SH  = 19;

    localparam logic [4:0] FEB_COMMON = 5'd28;
    localparam logic [4:0] FEB_LEAP   = 5'd29;
    localparam logic [4:0] SEPT_FULL  = 5'd30;
    localparam logic [4:0] SEPT_SHORT = 5'd19;
    localparam logic [4:0] SEPT_JUMP  = 5'd11;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_jan1_en;

    typedef struct packed {
        logic d;
        logic e;
    } t_cell_en;

    // days in month for a common year, Gregorian lengths
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = FEB_COMMON;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // weekday shift of the first of month m from January 1, common year
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        unique case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd3;
            4'd4:    off = 3'd6;
            4'd5:    off = 3'd1;
            4'd6:    off = 3'd4;
            4'd7:    off = 3'd6;
            4'd8:    off = 3'd2;
            4'd9:    off = 3'd5;
            4'd10:   off = 3'd0;
            4'd11:   off = 3'd3;
            4'd12:   off = 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // x mod 7 by folding octal digits, since 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [YW-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]}
           + {3'd0, x[11:9]} + {3'd0, x[14:12]};
        s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

// ----- src/calendar_grid_day_number.sv -----
// Calendar grid day lookup: year, month and grid cell to day of month.
// One request per cycle is accepted while o_stall is low.
// Throughput set by the five-stage pipeline, which moves whenever its
// next stage is free. Synchronous active-low reset clears valid bits only.
// Depends on cgdn_pkg, cgdn_jan1 and cgdn_cell.
module calendar_grid_day_number (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [13:0] i_year_number,
    input  logic [3:0]  i_month_number,
    input  logic [2:0]  i_week_row,
    input  logic [2:0]  i_weekday_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_day_of_month
);

    logic [cgdn_pkg::NSTG-1:0] r_v, n_v, en;

    // a stage advances when it is empty or the one after it advances
    always_comb begin
        en[cgdn_pkg::NSTG-1] = !r_v[cgdn_pkg::NSTG-1] || !i_stall;
        for (int k = cgdn_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v[0] = en[0] ? i_valid : r_v[0];
        for (int k = 1; k < cgdn_pkg::NSTG; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[cgdn_pkg::NSTG-1];

    // carry the cell fields alongside the year pipeline
    logic [3:0] r_mon [3];
    logic [2:0] r_wk  [3];
    logic [2:0] r_wd  [3];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mon[0] <= i_month_number;
            r_wk[0]  <= i_week_row;
            r_wd[0]  <= i_weekday_column;
        end
        for (int k = 1; k < 3; k++) begin
            if (en[k]) begin
                r_mon[k] <= r_mon[k-1];
                r_wk[k]  <= r_wk[k-1];
                r_wd[k]  <= r_wd[k-1];
            end
        end
    end

    cgdn_pkg::t_jan1_en jan_en;
    cgdn_pkg::t_cell_en cell_en;

    assign jan_en.a  = en[0];
    assign jan_en.b  = en[1];
    assign jan_en.c  = en[2];
    assign cell_en.d = en[3];
    assign cell_en.e = en[4];

    logic [cgdn_pkg::YW-1:0] year_this, year_next;
    logic [2:0]              dow_this, dow_next;

    assign year_this = {1'b0, i_year_number};
    assign year_next = year_this + 15'd1;

    cgdn_jan1 u_jan1_this (
        .i_clk     (i_clk),
        .i_en      (jan_en),
        .i_year    (year_this),
        .o_weekday (dow_this)
    );

    cgdn_jan1 u_jan1_next (
        .i_clk     (i_clk),
        .i_en      (jan_en),
        .i_year    (year_next),
        .o_weekday (dow_next)
    );

    cgdn_cell u_cell (
        .i_clk      (i_clk),
        .i_en       (cell_en),
        .i_dow_this (dow_this),
        .i_dow_next (dow_next),
        .i_month    (r_mon[2]),
        .i_week     (r_wk[2]),
        .i_wday     (r_wd[2]),
        .o_day      (o_day_of_month)
    );

endmodule

// ----- src/cgdn_jan1.sv -----
// Three-stage pipeline giving the weekday of January 1 of a year.
// Depends on cgdn_pkg (constants, reciprocal of 100, mod7).
module cgdn_jan1 (
    input  logic                     i_clk,
    input  cgdn_pkg::t_jan1_en       i_en,
    input  logic [cgdn_pkg::YW-1:0]  i_year,
    output logic [2:0]               o_weekday
);

    // stage A: base count and century offsets
    logic [cgdn_pkg::YW-1:0] n_base, r_base_a, r_base_b;
    logic [cgdn_pkg::YW-1:0] n_cent, r_cent;
    logic [12:0]             n_quad, r_quad;
    logic                    n_greg, r_greg_a;
    logic                    n_sw, r_sw_a, r_sw_b;
    logic [cgdn_pkg::YW-1:0] y3, quad_diff;

    always_comb begin
        y3        = i_year + 15'd3;
        n_base    = i_year + 15'd4 + {2'b00, y3[14:2]};
        n_greg    = i_year > cgdn_pkg::YEAR_GREG_CUT;
        n_sw      = i_year > cgdn_pkg::YEAR_SWITCH;
        n_cent    = i_year - cgdn_pkg::YEAR_CENT_BASE;
        quad_diff = i_year - cgdn_pkg::YEAR_QUAD_BASE;
        // floor(x/400) = floor(floor(x/4)/100)
        n_quad    = quad_diff[14:2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_base_a <= n_base;
            r_cent   <= n_cent;
            r_quad   <= n_quad;
            r_greg_a <= n_greg;
            r_sw_a   <= n_sw;
        end
    end

    // stage B: divide both offsets by 100
    logic [27:0] prod_cent, prod_quad;
    logic [7:0]  n_qc, r_qc;
    logic [5:0]  n_qq, r_qq;

    always_comb begin
        prod_cent = {13'd0, r_cent} * {15'd0, cgdn_pkg::RECIP_100};
        prod_quad = {15'd0, r_quad} * {15'd0, cgdn_pkg::RECIP_100};
        n_qc = r_greg_a ? prod_cent[cgdn_pkg::RECIP_SH +: 8] : 8'd0;
        n_qq = r_greg_a ? prod_quad[cgdn_pkg::RECIP_SH +: 6] : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_base_b <= r_base_a;
            r_sw_b   <= r_sw_a;
            r_qc     <= n_qc;
            r_qq     <= n_qq;
        end
    end

    // stage C: combine and reduce mod 7
    logic [cgdn_pkg::YW-1:0] day_cnt;
    logic [2:0]              n_wd, r_wd;

    always_comb begin
        day_cnt = r_base_b - {7'd0, r_qc} + {9'd0, r_qq}
                + (r_sw_b ? 15'd3 : 15'd0);
        n_wd    = cgdn_pkg::mod7(day_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            r_wd <= n_wd;
        end
    end

    assign o_weekday = r_wd;

endmodule

// ----- src/cgdn_cell.sv -----
// Two-stage back end: classify the year, find the month start and
// month length, then map the grid cell to a date.
// Depends on cgdn_pkg (month tables, month and length constants).
module cgdn_cell (
    input  logic               i_clk,
    input  cgdn_pkg::t_cell_en i_en,
    input  logic [2:0]         i_dow_this,
    input  logic [2:0]         i_dow_next,
    input  logic [3:0]         i_month,
    input  logic [2:0]         i_week,
    input  logic [2:0]         i_wday,
    output logic [4:0]         o_day
);

    // stage D
    logic [3:0] gap;
    logic       common, switch_yr, mon_ok;
    logic [4:0] n_dim, r_dim;
    logic [4:0] start_sum;
    logic [2:0] n_dow, r_dow;
    logic [2:0] r_week, r_wday;

    always_comb begin
        gap = {1'b0, i_dow_next} + 4'd7 - {1'b0, i_dow_this};
        if (gap >= 4'd7) begin
            gap = gap - 4'd7;
        end
        common    = gap == 4'd1;
        switch_yr = (gap != 4'd1) && (gap != 4'd2);
        mon_ok    = (i_month >= cgdn_pkg::MON_JAN) && (i_month <= cgdn_pkg::MON_DEC);

        if (!mon_ok) begin
            n_dim = 5'd0;
        end else if (i_month == cgdn_pkg::MON_FEB) begin
            n_dim = common ? cgdn_pkg::FEB_COMMON : cgdn_pkg::FEB_LEAP;
        end else if (i_month == cgdn_pkg::MON_SEP) begin
            n_dim = switch_yr ? cgdn_pkg::SEPT_SHORT : cgdn_pkg::SEPT_FULL;
        end else begin
            n_dim = cgdn_pkg::month_len(i_month);
        end

        // short September pulls later months back 11 days, i.e. +3 mod 7
        start_sum = {2'b00, i_dow_this} + {2'b00, cgdn_pkg::month_offset(i_month)}
                  + ((i_month > cgdn_pkg::MON_FEB && !common) ? 5'd1 : 5'd0)
                  + ((i_month > cgdn_pkg::MON_SEP && switch_yr) ? 5'd3 : 5'd0);
        if (start_sum >= 5'd7) begin
            start_sum = start_sum - 5'd7;
        end
        if (start_sum >= 5'd7) begin
            start_sum = start_sum - 5'd7;
        end
        n_dow = start_sum[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.d) begin
            r_dim  <= n_dim;
            r_dow  <= n_dow;
            r_week <= i_week;
            r_wday <= i_wday;
        end
    end

    // stage E
    logic [5:0] cell_idx, today;
    logic [4:0] n_day, r_day;

    always_comb begin
        cell_idx = {r_week, 3'd0} - {3'd0, r_week} + {3'd0, r_wday} + 6'd1;
        today    = cell_idx - {3'd0, r_dow};
        n_day    = 5'd0;
        if ((cell_idx > {3'd0, r_dow}) && (today <= {1'b0, r_dim})) begin
            // dates jump from 2 to 14 in the switch month
            if ((r_dim == cgdn_pkg::SEPT_SHORT) && (today >= 6'd3)) begin
                n_day = today[4:0] + cgdn_pkg::SEPT_JUMP;
            end else begin
                n_day = today[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.e) begin
            r_day <= n_day;
        end
    end

    assign o_day = r_day;

endmodule

// ----- bench/calendar_grid_day_number_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for calendar_grid_day_number: predicts each grid cell's date on its own.
// Needs cgdn_pkg (month codes) and the calendar_grid_day_number RTL.
module calendar_grid_day_number_tb;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [2:0]  row;
        logic [2:0]  col;
    } t_cell_query;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_TOGGLE,
        STALL_BLOCK
    } t_stall_mode;

    // weekday gap to the next January 1 for each kind of year
    localparam int unsigned GAP_COMMON = 1;
    localparam int unsigned GAP_LEAP   = 2;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [13:0] i_year_number    = '0;
    logic [3:0]  i_month_number   = '0;
    logic [2:0]  i_week_row       = '0;
    logic [2:0]  i_weekday_column = '0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [4:0]  o_day_of_month;

    t_cell_query pending_queries[$];
    logic [4:0]  expected_days[$];
    int unsigned accepted_count = 0;
    int unsigned total_requests = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned stall_phase    = 0;
    t_stall_mode stall_mode     = STALL_NONE;
    t_cell_query next_query;
    logic        next_stall;
    logic [4:0]  expected_day;

    calendar_grid_day_number uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_year_number    (i_year_number),
        .i_month_number   (i_month_number),
        .i_week_row       (i_week_row),
        .i_weekday_column (i_weekday_column),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_day_of_month   (o_day_of_month)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Julian weekday of January 1, with the century fixes after 1800
    // and the eleven-day shift after the switch year
    function automatic int unsigned jan1_weekday(input int unsigned y);
        int unsigned d;
        d = y + 4 + (y + 3) / 4;
        if (y > 1800) begin
            d = d - (y - 1701) / 100;
            d = d + (y - 1601) / 400;
        end
        if (y > 1752) begin
            d = d + 3;
        end
        return d % 7;
    endfunction

    function automatic int unsigned month_length_of(input int unsigned m,
                                                    input int unsigned feb_len,
                                                    input int unsigned sep_len);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 11:              len = 30;
            default:               len = 0;
        endcase
        if (m == cgdn_pkg::MON_FEB) begin
            len = feb_len;
        end
        if (m == cgdn_pkg::MON_SEP) begin
            len = sep_len;
        end
        return len;
    endfunction

    function automatic logic [4:0] grid_day_for_cell(input t_cell_query q);
        int unsigned y;
        int unsigned m;
        int unsigned feb_len;
        int unsigned sep_len;
        int unsigned month_days;
        int unsigned first_dow;
        int unsigned i;
        int          day_num;
        logic [4:0]  day_out;
        y = q.year;
        m = q.month;
        day_out = '0;
        if (m >= cgdn_pkg::MON_JAN && m <= cgdn_pkg::MON_DEC) begin
            feb_len = 29;
            sep_len = 30;
            first_dow = jan1_weekday(y);
            case ((jan1_weekday(y + 1) + 7 - first_dow) % 7)
                GAP_COMMON: feb_len = 28;
                GAP_LEAP:   feb_len = 29;
                default:    sep_len = 19;  // switch year
            endcase
            month_days = month_length_of(m, feb_len, sep_len);
            for (i = 1; i < m; i++) begin
                first_dow = first_dow + month_length_of(i, feb_len, sep_len);
            end
            first_dow = first_dow % 7;
            day_num = int'(q.row) * 7 + int'(q.col) - int'(first_dow) + 1;
            if (day_num > 0 && day_num <= int'(month_days)) begin
                // short September skips from the 2nd to the 14th
                if (month_days == 19 && day_num >= 3) begin
                    day_num = day_num + 11;
                end
                day_out = day_num[4:0];
            end
        end
        return day_out;
    endfunction

    task automatic queue_cell_query(input int unsigned y, input int unsigned m,
                                    input int unsigned r, input int unsigned c);
        t_cell_query q;
        q.year  = y[13:0];
        q.month = m[3:0];
        q.row   = r[2:0];
        q.col   = c[2:0];
        pending_queries.push_back(q);
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                next_query.year  = i_year_number;
                next_query.month = i_month_number;
                next_query.row   = i_week_row;
                next_query.col   = i_weekday_column;
                expected_days.push_back(grid_day_for_cell(next_query));
                accepted_count = accepted_count + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_queries.size() > 0) begin
                    next_query = pending_queries.pop_front();
                    i_year_number    <= next_query.year;
                    i_month_number   <= next_query.month;
                    i_week_row       <= next_query.row;
                    i_weekday_column <= next_query.col;
                    i_valid          <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: switch periodically among none, random, toggle and block patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_phase = stall_phase + 1;
            if (stall_phase % 64 == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
            end
            case (stall_mode)
                STALL_NONE:   next_stall = 1'b0;
                STALL_RANDOM: next_stall = ($urandom_range(0, 2) == 0);
                STALL_TOGGLE: next_stall = stall_phase[0];
                default:      next_stall = (stall_phase % 16) < 8;
            endcase
            i_stall <= next_stall;
        end
    end

    // result monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_days.size() == 0) begin
                $error("day_of_month: no result expected, actual %0d", o_day_of_month);
                fail_count = fail_count + 1;
            end else begin
                expected_day = expected_days.pop_front();
                if (o_day_of_month !== expected_day) begin
                    $error("day_of_month: expected %0d, actual %0d",
                           expected_day, o_day_of_month);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned pick;
        // switch year September around the jump and at its ends
        queue_cell_query(1752, 9, 0, 2);
        queue_cell_query(1752, 9, 0, 3);
        queue_cell_query(1752, 9, 0, 4);
        queue_cell_query(1752, 9, 2, 6);
        queue_cell_query(1752, 9, 3, 0);
        queue_cell_query(1752, 2, 4, 2);
        // century years on both sides of the Gregorian fix
        queue_cell_query(1800, 2, 4, 6);
        queue_cell_query(1900, 2, 4, 5);
        queue_cell_query(2000, 2, 4, 2);
        queue_cell_query(2100, 2, 4, 1);
        queue_cell_query(1751, 12, 0, 0);
        queue_cell_query(1753, 1, 0, 0);
        queue_cell_query(1801, 1, 0, 1);
        // year extremes, in range and beyond
        queue_cell_query(0, 1, 0, 0);
        queue_cell_query(1, 1, 0, 6);
        queue_cell_query(9999, 12, 5, 6);
        queue_cell_query(16383, 6, 3, 3);
        // bad months
        queue_cell_query(2024, 0, 2, 3);
        queue_cell_query(2024, 13, 2, 3);
        queue_cell_query(2024, 15, 2, 3);
        // rows and columns past the grid
        queue_cell_query(2024, 5, 6, 0);
        queue_cell_query(2024, 5, 7, 7);
        queue_cell_query(2024, 3, 5, 7);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // raw bits across the whole field range
                queue_cell_query($urandom_range(0, 16383), $urandom_range(0, 15),
                                 $urandom_range(0, 7), $urandom_range(0, 7));
            end else if (pick < 30) begin
                queue_cell_query($urandom_range(1740, 1810), $urandom_range(1, 12),
                                 $urandom_range(0, 5), $urandom_range(0, 6));
            end else begin
                queue_cell_query($urandom_range(1, 9999), $urandom_range(1, 12),
                                 $urandom_range(0, 5), $urandom_range(0, 6));
            end
        end
        total_requests = pending_queries.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_requests) @(posedge i_clk);
        while (expected_days.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cgdn_pkg.sv
src/cgdn_jan1.sv
src/cgdn_cell.sv
src/calendar_grid_day_number.sv
bench/calendar_grid_day_number_tb.sv
